/* src/sti_pkg.sv */
package sti_pkg;

  localparam int DEF_NUM_VECTORS = 64;
  localparam int VEC_W           = 6;
  localparam int MASK_W          = 48;
  localparam int CFG_IDX_W       = 3;
  localparam int DIV_STEPS       = 32;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam logic [VEC_W-1:0] FIRST_EXT = 6'd16;

  localparam logic [7:0] OFF_CTRL  = 8'h00;
  localparam logic [7:0] OFF_LOAD  = 8'h04;
  localparam logic [7:0] OFF_VAL   = 8'h08;
  localparam logic [7:0] OFF_CALIB = 8'h0c;

  localparam logic [15:0] RST_SCALE = 16'd1;
  localparam logic [23:0] RST_MIN   = 24'd1000;
  localparam logic [23:0] RST_MAX   = 24'hff_ffff;
  localparam logic [31:0] RST_LIMIT = 32'hffff_ffff;
  localparam logic [31:0] CNT_MAX   = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRASH   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 3'd0,
    CFG_MIN   = 3'd1,
    CFG_MAX   = 3'd2,
    CFG_LIMIT = 3'd3,
    CFG_CALIB = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_CLAMP,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic [1:0]       status;
    logic             pend_systick;
    logic             pend_valid;
    logic [VEC_W-1:0] pend_vector;
    logic             deadline_valid;
    logic [31:0]      deadline;
  } res_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_step;
    logic clamp;
    logic mul;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_mul;
    logic div_last;
  } stat_t;

endpackage

/* src/sti_if.sv */
interface sti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  offset;
  logic [31:0] write_data;
  logic [31:0] exec_blocks;
  logic [sti_pkg::MASK_W-1:0] irq_enabled_mask;

  modport source (
    output valid, operation, offset, write_data, exec_blocks, irq_enabled_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, offset, write_data, exec_blocks, irq_enabled_mask,
    output ready
  );
endinterface

interface sti_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;
  logic        pend_systick;
  logic        pend_valid;
  logic [sti_pkg::VEC_W-1:0] pend_vector;
  logic        deadline_valid;
  logic [31:0] deadline;

  modport source (
    output valid, read_data, status, pend_systick, pend_valid, pend_vector,
           deadline_valid, deadline,
    input  ready
  );
  modport sink (
    input  valid, read_data, status, pend_systick, pend_valid, pend_vector,
           deadline_valid, deadline,
    output ready
  );
endinterface

/* src/systick_timer_irq_injector_unit.sv */
// channel | dir | payload                                         | transfer when
// in_ch   | in  | operation offset write_data exec_blocks mask    | valid && ready
// out_ch  | out | read_data status pend_* deadline_valid deadline  | valid && ready
// cfg_    | in  | cfg_index cfg_wdata                             | cfg_we
//
// one item at a time: accept, execute, deliver
// reload and current value reads add a multiply step
// reload writes run the bit-serial divider, 32 steps plus a clamp step
// a new item is taken while the previous result waits in the output register
// synchronous active-low reset restores config, timer state and control state
module systick_timer_irq_injector_unit #(
  parameter int NUM_VECTORS = sti_pkg::DEF_NUM_VECTORS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  sti_in_if.sink                        in_ch,
  sti_out_if.source                     out_ch
);

  sti_pkg::cmd_t  cmd;
  sti_pkg::stat_t stat;
  sti_pkg::res_t  res;

  sti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sti_dpath #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_operation        (in_ch.operation),
    .in_offset           (in_ch.offset),
    .in_write_data       (in_ch.write_data),
    .in_exec_blocks      (in_ch.exec_blocks),
    .in_irq_enabled_mask (in_ch.irq_enabled_mask),
    .cmd                 (cmd),
    .stat                (stat),
    .res_out             (res)
  );

  assign out_ch.read_data      = res.read_data;
  assign out_ch.status         = res.status;
  assign out_ch.pend_systick   = res.pend_systick;
  assign out_ch.pend_valid     = res.pend_valid;
  assign out_ch.pend_vector    = res.pend_vector;
  assign out_ch.deadline_valid = res.deadline_valid;
  assign out_ch.deadline       = res.deadline;

endmodule

/* src/sti_ctrl.sv */
module sti_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  sti_pkg::stat_t stat,
  output sti_pkg::cmd_t  cmd
);

  sti_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic can_deliver;

  // output register is free when empty or being drained this cycle
  assign can_deliver = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sti_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sti_pkg::S_EXEC;
      end
      sti_pkg::S_EXEC: begin
        if (stat.need_div) state_nxt = sti_pkg::S_DIV;
        else if (stat.need_mul) state_nxt = sti_pkg::S_MUL;
        else state_nxt = sti_pkg::S_DONE;
      end
      sti_pkg::S_DIV: begin
        if (stat.div_last) state_nxt = sti_pkg::S_CLAMP;
      end
      sti_pkg::S_CLAMP: state_nxt = sti_pkg::S_DONE;
      sti_pkg::S_MUL:   state_nxt = sti_pkg::S_DONE;
      sti_pkg::S_DONE: begin
        if (can_deliver) state_nxt = sti_pkg::S_IDLE;
      end
      default: state_nxt = sti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      sti_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      sti_pkg::S_EXEC:  cmd.exec     = 1'b1;
      sti_pkg::S_DIV:   cmd.div_step = 1'b1;
      sti_pkg::S_CLAMP: cmd.clamp    = 1'b1;
      sti_pkg::S_MUL:   cmd.mul      = 1'b1;
      sti_pkg::S_DONE:  cmd.deliver  = can_deliver;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.deliver) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sti_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/sti_dpath.sv */
module sti_dpath #(
  parameter int NUM_VECTORS = sti_pkg::DEF_NUM_VECTORS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic [1:0]                    in_operation,
  input  logic [7:0]                    in_offset,
  input  logic [31:0]                   in_write_data,
  input  logic [31:0]                   in_exec_blocks,
  input  logic [sti_pkg::MASK_W-1:0]    in_irq_enabled_mask,
  input  sti_pkg::cmd_t                 cmd,
  output sti_pkg::stat_t                stat,
  output sti_pkg::res_t                 res_out
);

  localparam int RING = NUM_VECTORS - int'(sti_pkg::FIRST_EXT);
  localparam int VW   = sti_pkg::VEC_W;

  // configuration
  logic [15:0] scale_r;
  logic [23:0] min_r, max_r;
  logic [31:0] limit_r, calib_r;

  // timer state
  logic          en_r, ti_r, cs_r, flag_r;
  logic          en_nxt, ti_nxt, cs_nxt, flag_nxt;
  logic [31:0]   ps_r, ps_nxt;
  logic [31:0]   tc_r, tc_nxt;
  logic [VW-1:0] nv_r, nv_nxt;
  logic [23:0]   reload_r;

  // latched item
  logic [1:0]                 op_r;
  logic [7:0]                 off_r;
  logic [31:0]                wd_r, blk_r;
  logic [sti_pkg::MASK_W-1:0] mask_r;

  sti_pkg::res_t res_r, res_nxt, out_r;

  // divider and multiplier
  logic [15:0]                   rem_r;
  logic [31:0]                   quo_r;
  logic [sti_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [23:0]                   mul_a_r;
  logic [15:0]                   scale_eff;
  logic [16:0]                   rem_sh, rem_sub;
  logic                          rem_ge;
  logic [39:0]                   prod;
  logic [31:0]                   clamp_lo, clamp_hi;

  // read of current value
  logic [31:0] delta;
  logic [23:0] left;

  // vector search
  logic [RING-1:0] ring_mask, hi_mask;
  logic [VW-1:0]   start_off, hi_idx, lo_idx, sel_vec;
  logic [VW:0]     vec_inc;
  logic [VW-1:0]   vec_adv;
  logic [31:0]     tc_inc;
  logic            restart;

  assign scale_eff = (scale_r == 16'd0) ? 16'd1 : scale_r;

  always_comb begin
    stat.need_div = (op_r == sti_pkg::OP_WRITE) && (off_r == sti_pkg::OFF_LOAD);
    stat.need_mul = (op_r == sti_pkg::OP_READ) &&
                    ((off_r == sti_pkg::OFF_LOAD) || (off_r == sti_pkg::OFF_VAL));
    stat.div_last = (cnt_r == sti_pkg::DIV_CNT_W'(sti_pkg::DIV_STEPS - 1));
  end

  always_comb begin
    delta = (blk_r > ps_r) ? (blk_r - ps_r) : 32'd0;
    left  = (delta < {8'd0, reload_r}) ? 24'({8'd0, reload_r} - delta) : 24'd0;
  end

  // round-robin pick: first enabled vector at or after next_vector, else wrap
  always_comb begin
    ring_mask = mask_r[RING-1:0];
    start_off = nv_r - sti_pkg::FIRST_EXT;
    hi_idx    = '0;
    lo_idx    = '0;
    for (int i = 0; i < RING; i++) begin
      hi_mask[i] = ring_mask[i] && (VW'(i) >= start_off);
    end
    for (int i = RING - 1; i >= 0; i--) begin
      if (hi_mask[i]) hi_idx = VW'(i);
      if (ring_mask[i]) lo_idx = VW'(i);
    end
    sel_vec = ((|hi_mask) ? hi_idx : lo_idx) + sti_pkg::FIRST_EXT;
    vec_inc = {1'b0, sel_vec} + (VW+1)'(1);
    vec_adv = (vec_inc == (VW+1)'(NUM_VECTORS)) ? sti_pkg::FIRST_EXT : vec_inc[VW-1:0];
  end

  assign tc_inc = (tc_r == sti_pkg::CNT_MAX) ? tc_r : tc_r + 32'd1;

  always_comb begin
    res_nxt  = '0;
    en_nxt   = en_r;
    ti_nxt   = ti_r;
    cs_nxt   = cs_r;
    flag_nxt = flag_r;
    ps_nxt   = ps_r;
    tc_nxt   = tc_r;
    nv_nxt   = nv_r;
    restart  = 1'b0;
    case (op_r)
      sti_pkg::OP_READ: begin
        unique case (off_r)
          sti_pkg::OFF_CTRL: begin
            res_nxt.read_data = {15'd0, flag_r, 13'd0, cs_r, ti_r, en_r};
            flag_nxt          = 1'b1;
          end
          sti_pkg::OFF_LOAD, sti_pkg::OFF_VAL: ;
          sti_pkg::OFF_CALIB: res_nxt.read_data = calib_r;
          default: res_nxt.status = sti_pkg::ST_CRASH;
        endcase
      end
      sti_pkg::OP_WRITE: begin
        unique case (off_r)
          sti_pkg::OFF_CTRL: begin
            restart = wd_r[0] && (!en_r || (wd_r[2] != cs_r));
            en_nxt  = wd_r[0];
            ti_nxt  = wd_r[1];
            cs_nxt  = wd_r[2];
          end
          sti_pkg::OFF_LOAD: ;
          sti_pkg::OFF_VAL: begin
            flag_nxt = 1'b0;
            restart  = 1'b1;
          end
          default: res_nxt.status = sti_pkg::ST_CRASH;
        endcase
      end
      sti_pkg::OP_TICK: begin
        res_nxt.pend_systick = ti_r;
        if (|ring_mask) begin
          res_nxt.pend_valid  = 1'b1;
          res_nxt.pend_vector = sel_vec;
          nv_nxt              = vec_adv;
        end
        tc_nxt = tc_inc;
        if (tc_inc >= limit_r) res_nxt.status = sti_pkg::ST_TIMEOUT;
        else restart = 1'b1;
      end
      default: ;
    endcase
    if (restart) begin
      ps_nxt                 = blk_r;
      res_nxt.deadline_valid = 1'b1;
      res_nxt.deadline       = blk_r + {8'd0, reload_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= sti_pkg::RST_SCALE;
      min_r   <= sti_pkg::RST_MIN;
      max_r   <= sti_pkg::RST_MAX;
      limit_r <= sti_pkg::RST_LIMIT;
      calib_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sti_pkg::CFG_SCALE: scale_r <= cfg_wdata[15:0];
        sti_pkg::CFG_MIN:   min_r   <= cfg_wdata[23:0];
        sti_pkg::CFG_MAX:   max_r   <= cfg_wdata[23:0];
        sti_pkg::CFG_LIMIT: limit_r <= cfg_wdata;
        sti_pkg::CFG_CALIB: calib_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    clamp_lo = (quo_r < {8'd0, min_r}) ? {8'd0, min_r} : quo_r;
    clamp_hi = (clamp_lo > {8'd0, max_r}) ? {8'd0, max_r} : clamp_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      ti_r     <= 1'b0;
      cs_r     <= 1'b0;
      flag_r   <= 1'b0;
      ps_r     <= 32'd0;
      tc_r     <= 32'd0;
      nv_r     <= sti_pkg::FIRST_EXT;
      reload_r <= sti_pkg::RST_MIN;
    end else begin
      if (cmd.exec) begin
        en_r   <= en_nxt;
        ti_r   <= ti_nxt;
        cs_r   <= cs_nxt;
        flag_r <= flag_nxt;
        ps_r   <= ps_nxt;
        tc_r   <= tc_nxt;
        nv_r   <= nv_nxt;
      end
      if (cmd.clamp) reload_r <= clamp_hi[23:0];
    end
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[31]};
    rem_sub = rem_sh - {1'b0, scale_eff};
    rem_ge  = (rem_sh >= {1'b0, scale_eff});
  end

  assign prod = 40'(mul_a_r) * 40'(scale_eff);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      off_r  <= in_offset;
      wd_r   <= in_write_data;
      blk_r  <= in_exec_blocks;
      mask_r <= in_irq_enabled_mask;
    end
    if (cmd.exec) begin
      res_r   <= res_nxt;
      mul_a_r <= (off_r == sti_pkg::OFF_LOAD) ? reload_r : left;
      rem_r   <= 16'd0;
      quo_r   <= wd_r;
      cnt_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[30:0], rem_ge};
      cnt_r <= cnt_r + sti_pkg::DIV_CNT_W'(1);
    end
    if (cmd.mul) res_r.read_data <= {8'd0, prod[23:0]};
    if (cmd.deliver) out_r <= res_r;
  end

  assign res_out = out_r;

endmodule
